// File: design/critical_signal_timeout_monitor_top_defines.svh
// ----------------------------------------------------------------------------
// Critical signal timeout monitor - assertion macros
// Shared assertion wrappers for the monitor's RTL. Clocked on clock.
// ----------------------------------------------------------------------------
`ifndef CRITICAL_SIGNAL_TIMEOUT_MONITOR_TOP_DEFINES_SVH
`define CRITICAL_SIGNAL_TIMEOUT_MONITOR_TOP_DEFINES_SVH

// Checked outside reset only.
`define CTM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define CTM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// File: design/ctmon_pkg.sv
// ----------------------------------------------------------------------------
// Critical signal timeout monitor - package
// Field widths, transaction kind codes, register indexes and cell link types.
// ----------------------------------------------------------------------------
package ctmon_pkg;

   localparam int ID_W       = 29;
   localparam int TICK_W     = 32;
   localparam int KIND_W     = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;
   localparam int ID_REGS    = 4;
   localparam int ID_IDX_W   = 2;

   // transaction kinds
   localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FRAME = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CHECK = 3'd2;
   localparam logic [KIND_W-1:0] KIND_START = 3'd3;
   localparam logic [KIND_W-1:0] KIND_STOP  = 3'd4;

   // register indexes (byte address / 4)
   localparam logic [REG_IDX_W-1:0] REG_WATCHED_ID_0 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_TIMEOUT      = 3'd4;

   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd1000;

   // per-transaction controls broadcast to every cell
   typedef struct packed {
      logic            frame;
      logic            start;
      logic [ID_W-1:0] frame_id;
   } cell_op_type;

   // data handed from one cell to the next
   typedef struct packed {
      logic            matched;
      logic            fail;
      logic [ID_W-1:0] fail_id;
   } cell_link_type;

endpackage

// File: design/ctmon_cell.sv
// ----------------------------------------------------------------------------
// Critical signal timeout monitor - slot cell
// Holds one slot's last-seen stamp; matches frames and checks the slot's age.
// ----------------------------------------------------------------------------
module ctmon_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              op_en,
   input  ctmon_pkg::cell_op_type            op,
   input  logic [ctmon_pkg::ID_W-1:0]        watched_id,
   input  logic [ctmon_pkg::TICK_W-1:0]      tick_count,
   input  logic [ctmon_pkg::TICK_W-1:0]      timeout_ticks,
   input  ctmon_pkg::cell_link_type          link_in,
   output ctmon_pkg::cell_link_type          link_out
);

   logic [ctmon_pkg::TICK_W-1:0] last_seen_ff;
   logic [ctmon_pkg::TICK_W-1:0] last_seen_in;
   logic [ctmon_pkg::TICK_W-1:0] age;
   logic                         hit;
   logic                         too_old;

   assign hit     = op.frame && (watched_id == op.frame_id);
   assign age     = tick_count - last_seen_ff;   // wraps mod 2^32
   assign too_old = age > timeout_ticks;

   // lowest matching slot wins the stamp; highest failing slot wins the id
   always_comb begin
      link_out.matched = link_in.matched | hit;
      link_out.fail    = link_in.fail | too_old;
      link_out.fail_id = too_old ? watched_id : link_in.fail_id;
   end

   always_comb begin
      last_seen_in = last_seen_ff;
      if (op.start) begin
         last_seen_in = '0;
      end else if (hit && !link_in.matched) begin
         last_seen_in = tick_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seen_ff <= '0;
      end else if (op_en) begin
         last_seen_ff <= last_seen_in;
      end
   end

endmodule

// File: design/critical_signal_timeout_monitor_top.sv
// ----------------------------------------------------------------------------
// Critical signal timeout monitor - top level
// Watchdog over safety-critical bus messages with a row of per-slot cells.
// ----------------------------------------------------------------------------
// One transaction is taken every clock while req_stall is low. Each input
// transaction is a tick, a frame, a check, a start or a stop; each yields
// exactly one result, registered and presented on the rsp_ channel the cycle
// after acceptance. Throughput is one transaction per clock as long as
// rsp_stall is low; req_stall rises only while a result is held waiting.
// The per-transaction path is the row of NUM_SIGNALS slot cells: each cell
// matches the frame id and compares its wrapped age against timeout_ticks in
// parallel, and the priority (first match / last failure) ripples along the
// row. Registers (APB, 4-byte stride): watched_id_0..3 at 0x00..0x0C,
// timeout_ticks at 0x10 (reset 1000). Write registers only while idle.
// No clearing pass after reset: all state resets at once.
// ----------------------------------------------------------------------------
`include "critical_signal_timeout_monitor_top_defines.svh"

module critical_signal_timeout_monitor_top #(
   parameter int NUM_SIGNALS = 4   // 1..6 slots; slots above 4 watch id 0
) (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ctmon_pkg::KIND_W-1:0]        req_kind,
   input  logic [ctmon_pkg::ID_W-1:0]          req_frame_id,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_is_critical,
   output logic                                rsp_circuit_closed,
   output logic                                rsp_fault_now,
   output logic [ctmon_pkg::ID_W-1:0]          rsp_last_fail_id,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ctmon_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ctmon_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ctmon_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [ctmon_pkg::ID_W-1:0]      watched_id_ff [ctmon_pkg::ID_REGS];
   logic [ctmon_pkg::TICK_W-1:0]    timeout_ff;
   logic [ctmon_pkg::REG_IDX_W-1:0] csr_idx;
   logic                            csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[ctmon_pkg::CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ctmon_pkg::ID_REGS; i++) begin
            watched_id_ff[i] <= '0;
         end
         timeout_ff <= ctmon_pkg::TIMEOUT_RESET;
      end else if (csr_wr) begin
         // id registers of slots that do not exist ignore writes
         if ((int'(csr_idx) < ctmon_pkg::ID_REGS) && (int'(csr_idx) < NUM_SIGNALS)) begin
            watched_id_ff[csr_idx[ctmon_pkg::ID_IDX_W-1:0]] <=
               csr_pwdata[ctmon_pkg::ID_W-1:0];
         end else if (csr_idx == ctmon_pkg::REG_TIMEOUT) begin
            timeout_ff <= csr_pwdata;
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (int'(csr_idx) < ctmon_pkg::ID_REGS) begin
         csr_prdata = {{(ctmon_pkg::CSR_DATA_W - ctmon_pkg::ID_W){1'b0}},
                       watched_id_ff[csr_idx[ctmon_pkg::ID_IDX_W-1:0]]};
      end else if (csr_idx == ctmon_pkg::REG_TIMEOUT) begin
         csr_prdata = timeout_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Handshake: one output register; accept when it is free or draining
   // ---------------------------------------------------------------------
   logic rsp_valid_ff;
   logic accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // Decode
   // ---------------------------------------------------------------------
   logic                   running_ff;
   logic                   is_tick;
   logic                   is_frame;
   logic                   is_check;
   logic                   is_start;
   logic                   is_stop;
   ctmon_pkg::cell_op_type op;

   always_comb begin
      is_tick  = 1'b0;
      is_frame = 1'b0;
      is_check = 1'b0;
      is_start = 1'b0;
      is_stop  = 1'b0;
      case (req_kind)
         ctmon_pkg::KIND_TICK:  is_tick  = 1'b1;
         ctmon_pkg::KIND_FRAME: is_frame = 1'b1;
         ctmon_pkg::KIND_CHECK: is_check = 1'b1;
         ctmon_pkg::KIND_START: is_start = 1'b1;
         ctmon_pkg::KIND_STOP:  is_stop  = 1'b1;
         default: ;             // unused kinds report state only
      endcase
   end

   assign op.frame    = is_frame;
   assign op.start    = is_start;
   assign op.frame_id = req_frame_id;

   // ---------------------------------------------------------------------
   // Row of slot cells
   // ---------------------------------------------------------------------
   logic [ctmon_pkg::TICK_W-1:0] tick_ff;
   logic [ctmon_pkg::ID_W-1:0]   slot_id [NUM_SIGNALS];
   ctmon_pkg::cell_link_type     link    [NUM_SIGNALS+1];

   assign link[0] = '0;

   for (genvar g = 0; g < NUM_SIGNALS; g++) begin : g_slot
      if (g < ctmon_pkg::ID_REGS) begin : g_reg
         assign slot_id[g] = watched_id_ff[g];
      end else begin : g_fixed
         assign slot_id[g] = '0;
      end

      ctmon_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .op_en         (accept),
         .op            (op),
         .watched_id    (slot_id[g]),
         .tick_count    (tick_ff),
         .timeout_ticks (timeout_ff),
         .link_in       (link[g]),
         .link_out      (link[g+1])
      );
   end

   // ---------------------------------------------------------------------
   // Global state and result
   // ---------------------------------------------------------------------
   logic [ctmon_pkg::TICK_W-1:0] tick_in;
   logic                         running_in;
   logic [ctmon_pkg::ID_W-1:0]   failed_id_ff;
   logic [ctmon_pkg::ID_W-1:0]   failed_id_in;
   logic                         closed_ff;
   logic                         closed_in;
   logic                         check_run;
   logic                         fault;

   logic                         rsp_is_critical_ff;
   logic                         rsp_circuit_closed_ff;
   logic                         rsp_fault_now_ff;
   logic [ctmon_pkg::ID_W-1:0]   rsp_last_fail_id_ff;

   assign check_run = is_check && running_ff;
   assign fault     = check_run && link[NUM_SIGNALS].fail;

   always_comb begin
      tick_in      = tick_ff;
      running_in   = running_ff;
      failed_id_in = failed_id_ff;
      closed_in    = closed_ff;
      if (is_tick && running_ff) begin
         tick_in = tick_ff + ctmon_pkg::TICK_W'(1);
      end
      if (check_run) begin
         closed_in = !link[NUM_SIGNALS].fail;
         if (link[NUM_SIGNALS].fail) begin
            failed_id_in = link[NUM_SIGNALS].fail_id;
         end
      end
      if (is_start) begin
         tick_in    = '0;
         running_in = 1'b1;
      end
      if (is_stop) begin
         running_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         running_ff   <= 1'b0;
         failed_id_ff <= '0;
         closed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            tick_ff      <= tick_in;
            running_ff   <= running_in;
            failed_id_ff <= failed_id_in;
            closed_ff    <= closed_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_is_critical_ff    <= is_frame && link[NUM_SIGNALS].matched;
         rsp_circuit_closed_ff <= closed_in;
         rsp_fault_now_ff      <= fault;
         rsp_last_fail_id_ff   <= failed_id_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_critical    = rsp_is_critical_ff;
   assign rsp_circuit_closed = rsp_circuit_closed_ff;
   assign rsp_fault_now      = rsp_fault_now_ff;
   assign rsp_last_fail_id   = rsp_last_fail_id_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `CTM_ASSERT(a_fault_opens,
      rsp_valid_ff && rsp_fault_now_ff |-> !rsp_circuit_closed_ff,
      "fault reported with circuit closed")
   `CTM_ASSERT(a_crit_xor_fault,
      rsp_valid_ff |-> !(rsp_is_critical_ff && rsp_fault_now_ff),
      "critical and fault on one transaction")
   `CTM_ASSERT(a_tick_frozen,
      accept && is_tick && !running_ff |=> $stable(tick_ff),
      "tick counter moved while stopped")
   `CTM_ASSERT_ALWAYS(a_reset_idle,
      reset |=> !rsp_valid_ff,
      "result valid right after reset")

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Message timeout watchdog - self-checking testbench
// Drives bus events (ticks, frames, checks, start, stop and reserved kinds)
// through the req_ channel under random burst pacing, stalls the rsp_
// channel on its own pattern, and compares every result field against an
// in-bench predictor. The APB port is reprogrammed between phases, only
// while no transaction is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import ctmon_pkg::*;

   localparam int NUM_SLOTS      = 4;
   localparam int EVENTS_PER_RUN = 305;    // transactions per phase, the opening start included
   localparam int RANDOM_PHASES  = 6;
   localparam int WATCHDOG_LIMIT = 2000;   // cycles with no handshake at all

   // reserved kind codes: the block must ignore them
   localparam logic [KIND_W-1:0] KIND_RSVD_LO = 3'd5;
   localparam logic [KIND_W-1:0] KIND_RSVD_HI = 3'd7;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   frame_id;
   } bus_event_type;

   typedef struct packed {
      logic            is_critical;
      logic            circuit_closed;
      logic            fault_now;
      logic [ID_W-1:0] last_fail_id;
   } watchdog_status_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_EVERY_THIRD,
      STALL_HEAVY
   } stall_mode_type;

   // ------------------------------------------------------------------------
   // DUT hookup; every input has a known value from time zero
   // ------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [KIND_W-1:0]     req_kind = KIND_TICK;
   logic [ID_W-1:0]       req_frame_id = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_is_critical;
   logic                  rsp_circuit_closed;
   logic                  rsp_fault_now;
   logic [ID_W-1:0]       rsp_last_fail_id;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   critical_signal_timeout_monitor_top #(
      .NUM_SIGNALS (NUM_SLOTS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_frame_id       (req_frame_id),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_is_critical    (rsp_is_critical),
      .rsp_circuit_closed (rsp_circuit_closed),
      .rsp_fault_now      (rsp_fault_now),
      .rsp_last_fail_id   (rsp_last_fail_id),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor state: configuration and watchdog state, same as after reset
   // ------------------------------------------------------------------------
   logic [ID_W-1:0]   watch_id [NUM_SLOTS];
   logic [TICK_W-1:0] timeout_cfg = TIMEOUT_RESET;
   logic [TICK_W-1:0] tick_cnt = '0;
   logic [TICK_W-1:0] stamp [NUM_SLOTS];
   logic              run_on = 1'b0;
   logic [ID_W-1:0]   fail_id = '0;
   logic              circ_closed = 1'b0;

   bus_event_type       event_q[$];    // not yet accepted by the block
   watchdog_status_type status_q[$];   // predicted, not yet seen on rsp_
   watchdog_status_type rsp_want;

   int mismatch_count = 0;
   int req_total;                   // accepted transactions (driver only)
   int rsp_total;                   // received results, nonblocking
   int idle_cycles;

   // Advance the predictor by one accepted transaction.
   function automatic watchdog_status_type apply_bus_event(bus_event_type ev);
      watchdog_status_type st;
      logic [TICK_W-1:0] age;
      st = '0;
      case (ev.kind)
         KIND_TICK: begin
            if (run_on) tick_cnt = tick_cnt + TICK_W'(1);
         end
         KIND_FRAME: begin
            // first matching slot wins, even while stopped
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (!st.is_critical && watch_id[i] == ev.frame_id) begin
                  stamp[i] = tick_cnt;
                  st.is_critical = 1'b1;
               end
            end
         end
         KIND_CHECK: begin
            if (run_on) begin
               // wrapped age; highest failing slot ends up recorded
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  age = tick_cnt - stamp[i];
                  if (age > timeout_cfg) begin
                     st.fault_now = 1'b1;
                     fail_id = watch_id[i];
                  end
               end
               circ_closed = !st.fault_now;
            end
         end
         KIND_START: begin
            tick_cnt = '0;
            for (int i = 0; i < NUM_SLOTS; i++) stamp[i] = '0;
            run_on = 1'b1;
         end
         KIND_STOP: begin
            run_on = 1'b0;
         end
         default: ;
      endcase
      st.circuit_closed = circ_closed;
      st.last_fail_id   = fail_id;
      return st;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_event(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id);
      bus_event_type ev;
      ev.kind     = kind;
      ev.frame_id = id;
      event_q.push_back(ev);
   endtask

   // Mostly well-formed traffic: ticks, frames that hit watched IDs, checks.
   // Start/stop and reserved kinds are sprinkled in as noise.
   function automatic bus_event_type random_event();
      bus_event_type ev;
      int r;
      r = $urandom_range(0, 99);
      ev.frame_id = ID_W'($urandom);
      if (r < 4)       ev.kind = KIND_START;
      else if (r < 6)  ev.kind = KIND_STOP;
      else if (r < 8)  ev.kind = KIND_W'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI));
      else if (r < 42) ev.kind = KIND_TICK;
      else if (r < 78) begin
         ev.kind = KIND_FRAME;
         if ($urandom_range(0, 99) < 65)
            ev.frame_id = watch_id[$urandom_range(0, NUM_SLOTS-1)];
      end
      else ev.kind = KIND_CHECK;
      return ev;
   endfunction

   // APB write: setup cycle, then access until pready; predictor follows.
   task automatic csr_write(input logic [REG_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx < ID_REGS) begin
         if (idx < NUM_SLOTS) watch_id[idx[ID_IDX_W-1:0]] = data[ID_W-1:0];
      end else if (idx == REG_TIMEOUT) begin
         timeout_cfg = data;
      end
   endtask

   // Idle = nothing queued and nothing outstanding; the extra wait is margin.
   task automatic wait_idle();
      do @(posedge clock); while (event_q.size() != 0 || status_q.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Sequencer: reset, directed part, then random phases with new settings
   // ------------------------------------------------------------------------
   initial begin
      logic [CSR_DATA_W-1:0] tmo;
      logic [CSR_DATA_W-1:0] id_val [NUM_SLOTS];
      for (int i = 0; i < NUM_SLOTS; i++) begin
         watch_id[i] = '0;
         stamp[i]    = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed setup: max ID (upper bits must be masked off), ID zero, and
      // a duplicated ID in slots 2/3 written with junk above bit 28.
      // Timeout 0 so one tick is enough to fail.
      csr_write(REG_WATCHED_ID_0,        32'hFFFF_FFFF);
      csr_write(REG_WATCHED_ID_0 + 3'd1, 32'h0000_0000);
      csr_write(REG_WATCHED_ID_0 + 3'd2, 32'h0ABC_DEF1);
      csr_write(REG_WATCHED_ID_0 + 3'd3, 32'hEABC_DEF1);
      csr_write(REG_TIMEOUT,             32'd0);

      // stopped: check does nothing, tick frozen, frame still stamps
      push_event(KIND_CHECK,       29'h0);
      push_event(KIND_TICK,        29'h1FFF_FFFF);
      push_event(KIND_FRAME,       29'h1FFF_FFFF);
      push_event(KIND_FRAME,       29'h0001_2345);
      push_event(KIND_RSVD_LO,     29'h1FFF_FFFF);
      push_event(KIND_RSVD_LO + 1, 29'h0);
      push_event(KIND_RSVD_HI,     29'h0ABC_DEF1);
      // running: clean check closes the circuit, then an aged slot opens it
      push_event(KIND_START,       29'h0);
      push_event(KIND_CHECK,       29'h0);
      push_event(KIND_TICK,        29'h0);
      push_event(KIND_FRAME,       29'h0ABC_DEF1);   // duplicate: slot 2 only
      push_event(KIND_CHECK,       29'h0);
      push_event(KIND_FRAME,       29'h0);
      push_event(KIND_FRAME,       29'h1FFF_FFFF);
      push_event(KIND_CHECK,       29'h0);           // slot 3 never refreshed
      // stop freezes, restart while running clears ages
      push_event(KIND_STOP,        29'h0);
      push_event(KIND_TICK,        29'h0);
      push_event(KIND_CHECK,       29'h0);
      push_event(KIND_FRAME,       29'h0);
      push_event(KIND_START,       29'h0);
      push_event(KIND_START,       29'h1555_5555);
      push_event(KIND_CHECK,       29'h0AAA_AAAA);
      push_event(KIND_TICK,        29'h0);
      push_event(KIND_TICK,        29'h0);
      push_event(KIND_CHECK,       29'h0);
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       tmo = 32'hFFFF_FFFF;      // can never time out
            1:       tmo = 32'd0;              // any tick is too old
            RANDOM_PHASES-1: tmo = TIMEOUT_RESET;
            default: tmo = $urandom_range(1, 16);
         endcase
         for (int i = 0; i < NUM_SLOTS; i++) begin
            case ($urandom_range(0, 5))
               0:       id_val[i] = '0;
               1:       id_val[i] = 32'h1FFF_FFFF;
               2:       id_val[i] = (i > 0) ? id_val[0] : $urandom;
               default: id_val[i] = $urandom;
            endcase
            csr_write(REG_WATCHED_ID_0 + i[REG_IDX_W-1:0], id_val[i]);
         end
         csr_write(REG_TIMEOUT, tmo);
         // unmapped index: the block must drop it
         csr_write(REG_TIMEOUT + REG_IDX_W'($urandom_range(1, 3)), $urandom);

         push_event(KIND_START, ID_W'($urandom));
         for (int n = 1; n < EVENTS_PER_RUN; n++) event_q.push_back(random_event());
         wait_idle();
      end

      repeat (4) @(posedge clock);
      if (status_q.size() != 0) report_mismatch("results never delivered", status_q.size(), 0);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Driver: bursts of random length with random gaps; now and then holds off
   // until every outstanding result has come back.
   // ------------------------------------------------------------------------
   int burst_left;
   int gap_left;
   bit drain_hold;
   bit send;

   always @(posedge clock) begin
      if (reset) begin
         req_valid    <= 1'b0;
         req_kind     <= KIND_TICK;
         req_frame_id <= '0;
         req_total    = 0;
         burst_left   = 0;
         gap_left     = 0;
         drain_hold   = 1'b0;
      end else begin
         // transaction taken: predict its result
         if (req_valid && !req_stall) begin
            status_q.push_back(apply_bus_event(event_q.pop_front()));
            req_total++;
            if ($urandom_range(0, 199) == 0) drain_hold = 1'b1;
         end
         // payload only moves when nothing is held on the port
         if (!req_valid || !req_stall) begin
            send = 1'b0;
            if (drain_hold) begin
               if (req_total == rsp_total) drain_hold = 1'b0;
            end else if (gap_left > 0) begin
               gap_left--;
            end else if (event_q.size() != 0) begin
               send = 1'b1;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
                  burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 250)
                                                           : $urandom_range(1, 12);
               end
            end
            req_valid <= send;
            if (send) begin
               req_kind     <= event_q[0].kind;
               req_frame_id <= event_q[0].frame_id;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each result against the oldest prediction and drives
   // rsp_stall from a pattern whose mode is redrawn at random.
   // ------------------------------------------------------------------------
   stall_mode_type stall_mode;
   int             mode_left;
   int             beat;
   logic           stall_next;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         rsp_total  <= 0;
         stall_mode = STALL_NONE;
         mode_left  = 0;
         beat       = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_total <= rsp_total + 1;
            if (status_q.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_last_fail_id, 0);
            end else begin
               rsp_want = status_q.pop_front();
               if (rsp_is_critical !== rsp_want.is_critical)
                  report_mismatch("is_critical", rsp_is_critical, rsp_want.is_critical);
               if (rsp_circuit_closed !== rsp_want.circuit_closed)
                  report_mismatch("circuit_closed", rsp_circuit_closed,
                                  rsp_want.circuit_closed);
               if (rsp_fault_now !== rsp_want.fault_now)
                  report_mismatch("fault_now", rsp_fault_now, rsp_want.fault_now);
               if (rsp_last_fail_id !== rsp_want.last_fail_id)
                  report_mismatch("last_fail_id", rsp_last_fail_id, rsp_want.last_fail_id);
            end
         end
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 160);
         end else begin
            mode_left--;
         end
         beat++;
         case (stall_mode)
            STALL_LIGHT:       stall_next = ($urandom_range(0, 3) == 0);
            STALL_EVERY_THIRD: stall_next = (beat % 3 == 2);
            STALL_HEAVY:       stall_next = ($urandom_range(0, 9) < 7);
            default:           stall_next = 1'b0;
         endcase
         rsp_stall <= stall_next;
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: no handshake on either channel or the APB port for too long
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no progress for %0d cycles", $time, idle_cycles);
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// File: sim.f
+incdir+design
design/ctmon_pkg.sv
design/ctmon_cell.sv
design/critical_signal_timeout_monitor_top.sv
tb/tb.sv
